/* hw/rtl/source_lexer_tokenizer_core_defines.svh */
// ----------------------------------------------------------------------------
// lexer assertion macros
// shared property shorthands for the tokenizer core
// ----------------------------------------------------------------------------
`ifndef SOURCE_LEXER_TOKENIZER_CORE_DEFINES_SVH
`define SOURCE_LEXER_TOKENIZER_CORE_DEFINES_SVH

// plain property, checked every clock outside reset
`define SLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define SLT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/slt_pkg.sv */
// ----------------------------------------------------------------------------
// lexer package
// scan modes, token codes, character constants and keyword rom
// ----------------------------------------------------------------------------
package slt_pkg;

  typedef enum logic [12:0] {
    ST_IDLE   = 13'h0001,
    ST_LINE   = 13'h0002,
    ST_BLOCK  = 13'h0004,
    ST_BSTAR  = 13'h0008,
    ST_IDENT  = 13'h0010,
    ST_NUM    = 13'h0020,
    ST_NUMDOT = 13'h0040,
    ST_FRAC   = 13'h0080,
    ST_STR    = 13'h0100,
    ST_COPEN  = 13'h0200,
    ST_CESC   = 13'h0400,
    ST_CGOT   = 13'h0800,
    ST_OP     = 13'h1000
  } mode_e;

  localparam logic [3:0] CLS_IDENT   = 4'd0;
  localparam logic [3:0] CLS_KEYWORD = 4'd1;
  localparam logic [3:0] CLS_INT     = 4'd2;
  localparam logic [3:0] CLS_FLOAT   = 4'd3;
  localparam logic [3:0] CLS_STRING  = 4'd4;
  localparam logic [3:0] CLS_CHAR    = 4'd5;
  localparam logic [3:0] CLS_OP      = 4'd6;
  localparam logic [3:0] CLS_ERROR   = 4'd7;
  localparam logic [3:0] CLS_DIAG    = 4'd8;
  localparam logic [3:0] CLS_EOF     = 4'd9;

  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_UNEXPECTED   = 3'd1;
  localparam logic [2:0] ERR_OPEN_STRING  = 3'd2;
  localparam logic [2:0] ERR_EMPTY_CHAR   = 3'd3;
  localparam logic [2:0] ERR_BAD_CHAR     = 3'd4;
  localparam logic [2:0] ERR_OPEN_COMMENT = 3'd5;

  localparam logic [5:0] OP_LPAREN = 6'd0;
  localparam logic [5:0] OP_RPAREN = 6'd1;
  localparam logic [5:0] OP_LBRACE = 6'd2;
  localparam logic [5:0] OP_RBRACE = 6'd3;
  localparam logic [5:0] OP_LBRACK = 6'd4;
  localparam logic [5:0] OP_RBRACK = 6'd5;
  localparam logic [5:0] OP_SEMI   = 6'd6;
  localparam logic [5:0] OP_COMMA  = 6'd7;
  localparam logic [5:0] OP_COLON  = 6'd8;
  localparam logic [5:0] OP_DOT    = 6'd9;
  localparam logic [5:0] OP_QUEST  = 6'd10;
  localparam logic [5:0] OP_INC    = 6'd11;
  localparam logic [5:0] OP_ADDEQ  = 6'd12;
  localparam logic [5:0] OP_ADD    = 6'd13;
  localparam logic [5:0] OP_DEC    = 6'd14;
  localparam logic [5:0] OP_SUBEQ  = 6'd15;
  localparam logic [5:0] OP_ARROW  = 6'd16;
  localparam logic [5:0] OP_SUB    = 6'd17;
  localparam logic [5:0] OP_MULEQ  = 6'd18;
  localparam logic [5:0] OP_MUL    = 6'd19;
  localparam logic [5:0] OP_DIVEQ  = 6'd20;
  localparam logic [5:0] OP_DIV    = 6'd21;
  localparam logic [5:0] OP_MOD    = 6'd22;
  localparam logic [5:0] OP_EQ     = 6'd23;
  localparam logic [5:0] OP_ASSIGN = 6'd24;
  localparam logic [5:0] OP_NE     = 6'd25;
  localparam logic [5:0] OP_NOT    = 6'd26;
  localparam logic [5:0] OP_LE     = 6'd27;
  localparam logic [5:0] OP_LT     = 6'd28;
  localparam logic [5:0] OP_GE     = 6'd29;
  localparam logic [5:0] OP_GT     = 6'd30;
  localparam logic [5:0] OP_LAND   = 6'd31;
  localparam logic [5:0] OP_LOR    = 6'd32;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;

  typedef struct packed {
    logic       hit;
    logic [5:0] code;
  } code_t;

  localparam int KW_COUNT = 67;
  localparam int KW_BITS  = 128;

  // spellings right-justified, first character highest
  localparam logic [79:0] KW_TEXT [KW_COUNT] = '{
    {"thala", "pathy"}, 80'("aarambam"), 80'("nanba"), 80'("nanbi"),
    80'("makkal"), 80'("uruthi"), 80'("ghilli"), 80'("illana"), 80'("bigil"),
    80'("vaathi"), 80'("mersal"), 80'("thiruppi"), 80'("sollu"),
    80'("master"), 80'("varisu"), 80'("kaththi"), 80'("theri"),
    80'("pokkiri"), 80'("kaavalan"), 80'("beast"), 80'("leo"),
    80'("sarkar"), 80'("waiting"), 80'("goat"), 80'("thuppakki"),
    80'("thalaivaa"), 80'("vazhakku"), 80'("kutty"), 80'("nadu"),
    80'("vagai"), 80'("kadaisi"), 80'("varum"), 80'("kaathiru"),
    80'("int"), 80'("float"), 80'("bool"), 80'("string"), 80'("char"),
    80'("void"), 80'("null"), 80'("true"), 80'("false"), 80'("this"),
    80'("super"), 80'("break"), 80'("continue"), 80'("paaru"),
    80'("maathu"), 80'("seyal"), 80'("static"), 80'("as"),
    80'("aaguma"), 80'("operator"),
    80'("aama"), 80'("illa"), 80'("onnumilla"), 80'("naan"),
    80'("interval"), 80'("aduthu"), 80'("podhu"), 80'("maathiko"),
    80'("munnadi"), 80'("comeback"), 80'("yaaru"), 80'("ivan"),
    80'("yaarumilla"), 80'("mudivu")
  };

  localparam logic [5:0] KW_CODE [KW_COUNT] = '{
    6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10,
    6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20,
    6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30,
    6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40,
    6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd46, 6'd47, 6'd48, 6'd49, 6'd50,
    6'd51, 6'd52,
    6'd40, 6'd41, 6'd39, 6'd42, 6'd44, 6'd45, 6'd49, 6'd50, 6'd43, 6'd53,
    6'd54, 6'd55, 6'd56, 6'd5
  };

  function automatic code_t kw_lookup(input logic [KW_BITS-1:0] w);
    code_t r;
    r = '0;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (!r.hit && w == KW_BITS'(KW_TEXT[i])) begin
        r.hit  = 1'b1;
        r.code = KW_CODE[i];
      end
    end
    return r;
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == CH_USCORE;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return b == CH_SPACE || b == CH_CR || b == CH_TAB || b == CH_LF;
  endfunction

  function automatic logic is_op_lead(input logic [7:0] b);
    return b == CH_PLUS || b == CH_MINUS || b == CH_STAR || b == CH_SLASH ||
           b == CH_EQ || b == CH_BANG || b == CH_LT || b == CH_GT ||
           b == CH_AMP || b == CH_PIPE;
  endfunction

  function automatic code_t single_code(input logic [7:0] b);
    code_t r;
    r.hit = 1'b1;
    case (b)
      CH_LPAREN: r.code = OP_LPAREN;
      CH_RPAREN: r.code = OP_RPAREN;
      CH_LBRACE: r.code = OP_LBRACE;
      CH_RBRACE: r.code = OP_RBRACE;
      CH_LBRACK: r.code = OP_LBRACK;
      CH_RBRACK: r.code = OP_RBRACK;
      CH_SEMI:   r.code = OP_SEMI;
      CH_COMMA:  r.code = OP_COMMA;
      CH_COLON:  r.code = OP_COLON;
      CH_DOT:    r.code = OP_DOT;
      CH_QUEST:  r.code = OP_QUEST;
      CH_PLUS:   r.code = OP_ADD;
      CH_MINUS:  r.code = OP_SUB;
      CH_STAR:   r.code = OP_MUL;
      CH_SLASH:  r.code = OP_DIV;
      CH_PCT:    r.code = OP_MOD;
      CH_EQ:     r.code = OP_ASSIGN;
      CH_BANG:   r.code = OP_NOT;
      CH_LT:     r.code = OP_LT;
      CH_GT:     r.code = OP_GT;
      default: begin
        r.hit  = 1'b0;
        r.code = '0;
      end
    endcase
    return r;
  endfunction

  function automatic code_t pair_code(input logic [7:0] a, input logic [7:0] b);
    code_t r;
    r.hit = 1'b1;
    case ({a, b})
      {CH_PLUS, CH_PLUS}:   r.code = OP_INC;
      {CH_PLUS, CH_EQ}:     r.code = OP_ADDEQ;
      {CH_MINUS, CH_MINUS}: r.code = OP_DEC;
      {CH_MINUS, CH_EQ}:    r.code = OP_SUBEQ;
      {CH_MINUS, CH_GT}:    r.code = OP_ARROW;
      {CH_STAR, CH_EQ}:     r.code = OP_MULEQ;
      {CH_SLASH, CH_EQ}:    r.code = OP_DIVEQ;
      {CH_EQ, CH_EQ}:       r.code = OP_EQ;
      {CH_BANG, CH_EQ}:     r.code = OP_NE;
      {CH_LT, CH_EQ}:       r.code = OP_LE;
      {CH_GT, CH_EQ}:       r.code = OP_GE;
      {CH_AMP, CH_AMP}:     r.code = OP_LAND;
      {CH_PIPE, CH_PIPE}:   r.code = OP_LOR;
      default: begin
        r.hit  = 1'b0;
        r.code = '0;
      end
    endcase
    return r;
  endfunction

  function automatic logic [7:0] decode_escape(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      CH_N:    r = CH_LF;
      CH_T:    r = CH_TAB;
      CH_R:    r = CH_CR;
      default: r = b;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/slt_ifs.sv */
// ----------------------------------------------------------------------------
// lexer channels
// valid/ready channels for source bytes and tokens
// ----------------------------------------------------------------------------
interface slt_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_in;

  modport source (output valid, kind, byte_in, input ready);
  modport sink (input valid, kind, byte_in, output ready);
endinterface

interface slt_out_if #(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS   = 20,
  parameter int COL_BITS    = 16
);
  logic                   valid;
  logic                   ready;
  logic [3:0]             token_class;
  logic [5:0]             sub_code;
  logic [2:0]             error_code;
  logic [OFFSET_BITS-1:0] start_offset;
  logic [OFFSET_BITS-1:0] token_length;
  logic [LINE_BITS-1:0]   line_from;
  logic [COL_BITS-1:0]    col_from;
  logic [LINE_BITS-1:0]   line_to;
  logic [COL_BITS-1:0]    col_to;
  logic [7:0]             char_value;
  logic                   last;

  modport source (output valid, token_class, sub_code, error_code, start_offset,
                  token_length, line_from, col_from, line_to, col_to,
                  char_value, last, input ready);
  modport sink (input valid, token_class, sub_code, error_code, start_offset,
                token_length, line_from, col_from, line_to, col_to,
                char_value, last, output ready);
endinterface

/* hw/rtl/source_lexer_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// source lexer tokenizer core
// streaming tokenizer: source bytes in, classified tokens out
// ----------------------------------------------------------------------------
// in_i carries one item per handshake: kind 0 with a source byte, or kind 1
// for end of source. out_o carries tokens; last marks the final token caused
// by one input item, and an item that causes no token gives nothing.
// The scanner takes one item per cycle while the queue has room and turns it
// into a record of up to three tokens in the same cycle; records wait in a
// four-entry queue, and the emitter sends one token per cycle from a
// registered output while out_o is not stalled. With the queue empty and out_o
// free, the first token of an item goes through the queue and the output
// register to out_o. Items flow one per cycle while they average at most one
// token; an item with several tokens holds the emitter until all are sent,
// and the queue absorbs such bursts before in_i.ready drops.
// Reset clears the scan state to between tokens at offset 0, line 1, col 1,
// and empties the queue; end of source resets only the scan state after its token.
// A stalled out_o keeps its token; the scanner runs on until the queue fills.
// ----------------------------------------------------------------------------
module source_lexer_tokenizer_core #(
  parameter int MAX_KEYWORD_LEN = 10,
  parameter int OFFSET_BITS     = 24,
  parameter int LINE_BITS       = 20,
  parameter int COL_BITS        = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  slt_in_if.sink     in_i,
  slt_out_if.source  out_o
);
  import slt_pkg::*;

  localparam int REC_W = 1 + 4 + 6 + 3 + 8 + 2 * (OFFSET_BITS + LINE_BITS + COL_BITS);
  localparam int ENT_W = 3 * REC_W;

  logic             take, push, pop, full, empty;
  logic [ENT_W-1:0] entry, head;

  assign in_i.ready = !full;
  assign take       = in_i.valid && !full;

  slt_front #(
    .MAX_KEYWORD_LEN(MAX_KEYWORD_LEN),
    .OFFSET_BITS(OFFSET_BITS),
    .LINE_BITS(LINE_BITS),
    .COL_BITS(COL_BITS),
    .ENT_W(ENT_W)
  ) u_front (
    .clk_i,
    .rst_ni,
    .take_i (take),
    .kind_i (in_i.kind),
    .byte_i (in_i.byte_in),
    .push_o (push),
    .entry_o(entry)
  );

  slt_fifo #(
    .WIDTH(ENT_W),
    .DEPTH(4)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i (push),
    .data_i (entry),
    .pop_i  (pop),
    .head_o (head),
    .full_o (full),
    .empty_o(empty)
  );

  slt_back #(
    .OFFSET_BITS(OFFSET_BITS),
    .LINE_BITS(LINE_BITS),
    .COL_BITS(COL_BITS),
    .ENT_W(ENT_W)
  ) u_back (
    .clk_i,
    .rst_ni,
    .head_i        (head),
    .empty_i       (empty),
    .pop_o         (pop),
    .valid_o       (out_o.valid),
    .ready_i       (out_o.ready),
    .token_class_o (out_o.token_class),
    .sub_code_o    (out_o.sub_code),
    .error_code_o  (out_o.error_code),
    .start_offset_o(out_o.start_offset),
    .token_length_o(out_o.token_length),
    .line_from_o   (out_o.line_from),
    .col_from_o    (out_o.col_from),
    .line_to_o     (out_o.line_to),
    .col_to_o      (out_o.col_to),
    .char_value_o  (out_o.char_value),
    .last_o        (out_o.last)
  );
endmodule

/* hw/rtl/slt_fifo.sv */
// ----------------------------------------------------------------------------
// lexer token queue
// small register fifo between the scanner and the token emitter
// ----------------------------------------------------------------------------
module slt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] head_o,
  output logic             full_o,
  output logic             empty_o
);
  `include "source_lexer_tokenizer_core_defines.svh"

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  function automatic logic [PW-1:0] inc_ptr(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? inc_ptr(wr_q) : wr_q;
    rd_d  = pop_i ? inc_ptr(rd_q) : rd_q;
    cnt_d = cnt_q + CW'(push_i) - CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  `SLT_IMPLY(a_fifo_no_overflow, push_i, !full_o, "push into full token queue")
  `SLT_IMPLY(a_fifo_no_underflow, pop_i, !empty_o, "pop from empty token queue")
endmodule

/* hw/rtl/slt_front.sv */
// ----------------------------------------------------------------------------
// lexer scanner
// classifies each item and builds up to three token records for it
// ----------------------------------------------------------------------------
module slt_front #(
  parameter int MAX_KEYWORD_LEN = 10,
  parameter int OFFSET_BITS     = 24,
  parameter int LINE_BITS       = 20,
  parameter int COL_BITS        = 16,
  parameter int ENT_W           = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic             kind_i,
  input  logic [7:0]       byte_i,
  output logic             push_o,
  output logic [ENT_W-1:0] entry_o
);
  import slt_pkg::*;
  `include "source_lexer_tokenizer_core_defines.svh"

  localparam int WL = $clog2(MAX_KEYWORD_LEN + 1);
  localparam int WI = $clog2(MAX_KEYWORD_LEN);

  typedef struct packed {
    logic                   vld;
    logic [3:0]             cls;
    logic [5:0]             sub;
    logic [2:0]             err;
    logic [7:0]             cv;
    logic [OFFSET_BITS-1:0] so;
    logic [LINE_BITS-1:0]   sl;
    logic [COL_BITS-1:0]    sc;
    logic [OFFSET_BITS-1:0] eo;
    logic [LINE_BITS-1:0]   el;
    logic [COL_BITS-1:0]    ec;
  } rec_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] off;
    logic [LINE_BITS-1:0]   line;
    logic [COL_BITS-1:0]    col;
  } pos_t;

  localparam pos_t POS_RESET = '{off: '0, line: LINE_BITS'(1), col: COL_BITS'(1)};

  mode_e      st_q, st_d;
  logic [7:0] wbuf_q [MAX_KEYWORD_LEN];
  logic [7:0] wbuf_d [MAX_KEYWORD_LEN];
  logic [WL-1:0] wlen_q, wlen_d;
  logic       wlong_q, wlong_d;
  logic       pesc_q, pesc_d;
  logic [7:0] held_q, held_d;
  pos_t       ts_q, ts_d, cur_q, cur_d, dot_q, dot_d, nxt;
  rec_t [2:0] slot;
  logic       take_en, do_flush, do_idle, eof_clr;
  logic [8*MAX_KEYWORD_LEN-1:0] word;
  code_t      kw, sc_b, pc_b, sc_h;
  logic [7:0] b;

  function automatic rec_t mk(input logic [3:0] cls, input logic [5:0] sub,
                              input logic [2:0] err, input logic [7:0] cv,
                              input pos_t s, input pos_t e);
    rec_t r;
    r.vld = 1'b1;
    r.cls = cls;
    r.sub = sub;
    r.err = err;
    r.cv  = cv;
    r.so  = s.off;
    r.sl  = s.line;
    r.sc  = s.col;
    r.eo  = e.off;
    r.el  = e.line;
    r.ec  = e.col;
    return r;
  endfunction

  assign b = byte_i;

  always_comb begin
    word = '0;
    for (int i = 0; i < MAX_KEYWORD_LEN; i++) begin
      if (WL'(i) < wlen_q) begin
        word = {word[8*MAX_KEYWORD_LEN-9:0], wbuf_q[i]};
      end
    end
  end

  assign kw   = kw_lookup(KW_BITS'(word));
  assign sc_b = single_code(b);
  assign pc_b = pair_code(held_q, b);
  assign sc_h = single_code(held_q);

  // position after taking the byte, saturating
  always_comb begin
    nxt.off = (&cur_q.off) ? cur_q.off : cur_q.off + 1'b1;
    if (b == CH_LF) begin
      nxt.line = (&cur_q.line) ? cur_q.line : cur_q.line + 1'b1;
      nxt.col  = COL_BITS'(1);
    end else begin
      nxt.line = cur_q.line;
      nxt.col  = (&cur_q.col) ? cur_q.col : cur_q.col + 1'b1;
    end
  end

  always_comb begin
    st_d     = st_q;
    wbuf_d   = wbuf_q;
    wlen_d   = wlen_q;
    wlong_d  = wlong_q;
    pesc_d   = pesc_q;
    held_d   = held_q;
    ts_d     = ts_q;
    dot_d    = dot_q;
    slot     = '0;
    take_en  = 1'b0;
    do_flush = 1'b0;
    do_idle  = 1'b0;
    eof_clr  = 1'b0;

    if (kind_i) begin
      do_flush = 1'b1;
      eof_clr  = 1'b1;
      slot[2]  = mk(CLS_EOF, '0, ERR_NONE, '0, cur_q, cur_q);
    end else begin
      case (st_q)
        ST_IDLE: do_idle = 1'b1;
        ST_LINE: begin
          take_en = 1'b1;
          if (b == CH_LF) st_d = ST_IDLE;
        end
        ST_BLOCK: begin
          take_en = 1'b1;
          if (b == CH_STAR) st_d = ST_BSTAR;
        end
        ST_BSTAR: begin
          take_en = 1'b1;
          if (b == CH_SLASH) st_d = ST_IDLE;
          else if (b != CH_STAR) st_d = ST_BLOCK;
        end
        ST_IDENT: begin
          if (is_alpha(b) || is_digit(b)) begin
            take_en = 1'b1;
            if (wlen_q < WL'(MAX_KEYWORD_LEN)) begin
              wbuf_d[wlen_q[WI-1:0]] = b;
              wlen_d = wlen_q + 1'b1;
            end else begin
              wlong_d = 1'b1;
            end
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        ST_NUM: begin
          if (is_digit(b)) begin
            take_en = 1'b1;
          end else if (b == CH_DOT) begin
            take_en = 1'b1;
            dot_d   = cur_q;
            st_d    = ST_NUMDOT;
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        ST_NUMDOT: begin
          if (is_digit(b)) begin
            take_en = 1'b1;
            st_d    = ST_FRAC;
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        ST_FRAC: begin
          if (is_digit(b)) begin
            take_en = 1'b1;
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        ST_STR: begin
          take_en = 1'b1;
          if (pesc_q) begin
            pesc_d = 1'b0;
          end else if (b == CH_BSLASH) begin
            pesc_d = 1'b1;
          end else if (b == CH_DQUOTE) begin
            slot[2] = mk(CLS_STRING, '0, ERR_NONE, '0, ts_q, nxt);
            st_d    = ST_IDLE;
          end
        end
        ST_COPEN: begin
          take_en = 1'b1;
          if (b == CH_SQUOTE) begin
            slot[2] = mk(CLS_ERROR, '0, ERR_EMPTY_CHAR, '0, ts_q, cur_q);
            st_d    = ST_IDLE;
          end else if (b == CH_BSLASH) begin
            st_d = ST_CESC;
          end else begin
            held_d = b;
            st_d   = ST_CGOT;
          end
        end
        ST_CESC: begin
          take_en = 1'b1;
          held_d  = decode_escape(b);
          st_d    = ST_CGOT;
        end
        ST_CGOT: begin
          if (b == CH_SQUOTE) begin
            take_en = 1'b1;
            slot[2] = mk(CLS_CHAR, '0, ERR_NONE, held_q, ts_q, nxt);
            st_d    = ST_IDLE;
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        ST_OP: begin
          if (pc_b.hit) begin
            take_en = 1'b1;
            slot[2] = mk(CLS_OP, pc_b.code, ERR_NONE, '0, ts_q, nxt);
            st_d    = ST_IDLE;
          end else if (held_q == CH_SLASH && b == CH_SLASH) begin
            take_en = 1'b1;
            st_d    = ST_LINE;
          end else if (held_q == CH_SLASH && b == CH_STAR) begin
            take_en = 1'b1;
            st_d    = ST_BLOCK;
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase
    end

    // pending token, ending at the position before this byte
    if (do_flush) begin
      case (st_q)
        ST_IDENT: begin
          if (kw.hit && !wlong_q) slot[0] = mk(CLS_KEYWORD, kw.code, ERR_NONE, '0, ts_q, cur_q);
          else slot[0] = mk(CLS_IDENT, '0, ERR_NONE, '0, ts_q, cur_q);
        end
        ST_NUM:    slot[0] = mk(CLS_INT, '0, ERR_NONE, '0, ts_q, cur_q);
        ST_NUMDOT: begin
          slot[0] = mk(CLS_INT, '0, ERR_NONE, '0, ts_q, dot_q);
          slot[1] = mk(CLS_OP, OP_DOT, ERR_NONE, '0, dot_q, cur_q);
        end
        ST_FRAC:   slot[0] = mk(CLS_FLOAT, '0, ERR_NONE, '0, ts_q, cur_q);
        ST_STR:    slot[0] = mk(CLS_ERROR, '0, ERR_OPEN_STRING, '0, ts_q, cur_q);
        ST_COPEN, ST_CESC: slot[0] = mk(CLS_ERROR, '0, ERR_BAD_CHAR, '0, ts_q, cur_q);
        ST_CGOT:   slot[0] = mk(CLS_ERROR, '0, ERR_BAD_CHAR, held_q, ts_q, cur_q);
        ST_OP: begin
          if (sc_h.hit) begin
            slot[0] = mk(CLS_OP, sc_h.code, ERR_NONE, '0, ts_q, cur_q);
          end else begin
            slot[0] = mk(CLS_ERROR, '0, ERR_UNEXPECTED, held_q, ts_q, cur_q);
          end
        end
        ST_BLOCK, ST_BSTAR: slot[0] = mk(CLS_DIAG, '0, ERR_OPEN_COMMENT, '0, ts_q, cur_q);
        default: ;
      endcase
      st_d = ST_IDLE;
    end

    if (do_idle) begin
      take_en = 1'b1;
      st_d    = ST_IDLE;
      if (!is_ws(b)) begin
        ts_d = cur_q;
        if (is_alpha(b)) begin
          wbuf_d[0] = b;
          wlen_d    = WL'(1);
          wlong_d   = 1'b0;
          st_d      = ST_IDENT;
        end else if (is_digit(b)) begin
          st_d = ST_NUM;
        end else if (b == CH_DQUOTE) begin
          pesc_d = 1'b0;
          st_d   = ST_STR;
        end else if (b == CH_SQUOTE) begin
          held_d = '0;
          st_d   = ST_COPEN;
        end else if (is_op_lead(b)) begin
          held_d = b;
          st_d   = ST_OP;
        end else if (sc_b.hit) begin
          slot[2] = mk(CLS_OP, sc_b.code, ERR_NONE, '0, cur_q, nxt);
        end else begin
          slot[2] = mk(CLS_ERROR, '0, ERR_UNEXPECTED, b, cur_q, nxt);
        end
      end
    end

    cur_d = take_en ? nxt : cur_q;

    if (eof_clr) begin
      st_d    = ST_IDLE;
      wlen_d  = '0;
      wlong_d = 1'b0;
      pesc_d  = 1'b0;
      held_d  = '0;
      ts_d    = POS_RESET;
      cur_d   = POS_RESET;
      dot_d   = POS_RESET;
    end
  end

  assign push_o  = take_i && (slot[0].vld || slot[1].vld || slot[2].vld);
  assign entry_o = slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      wlen_q  <= '0;
      wlong_q <= 1'b0;
      pesc_q  <= 1'b0;
      held_q  <= '0;
      ts_q    <= POS_RESET;
      cur_q   <= POS_RESET;
      dot_q   <= POS_RESET;
    end else if (take_i) begin
      st_q    <= st_d;
      wlen_q  <= wlen_d;
      wlong_q <= wlong_d;
      pesc_q  <= pesc_d;
      held_q  <= held_d;
      ts_q    <= ts_d;
      cur_q   <= cur_d;
      dot_q   <= dot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      wbuf_q <= wbuf_d;
    end
  end

  `SLT_IMPLY(a_front_eof_pushes, take_i && kind_i, push_o, "end of source made no token")
  `SLT_ASSERT(a_front_wlen_range, wlen_q <= WL'(MAX_KEYWORD_LEN), "word length overran buffer")
endmodule

/* hw/rtl/slt_back.sv */
// ----------------------------------------------------------------------------
// lexer token emitter
// walks the token records of each queued entry onto the output register
// ----------------------------------------------------------------------------
module slt_back #(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS   = 20,
  parameter int COL_BITS    = 16,
  parameter int ENT_W       = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [ENT_W-1:0]       head_i,
  input  logic                   empty_i,
  output logic                   pop_o,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [3:0]             token_class_o,
  output logic [5:0]             sub_code_o,
  output logic [2:0]             error_code_o,
  output logic [OFFSET_BITS-1:0] start_offset_o,
  output logic [OFFSET_BITS-1:0] token_length_o,
  output logic [LINE_BITS-1:0]   line_from_o,
  output logic [COL_BITS-1:0]    col_from_o,
  output logic [LINE_BITS-1:0]   line_to_o,
  output logic [COL_BITS-1:0]    col_to_o,
  output logic [7:0]             char_value_o,
  output logic                   last_o
);
  import slt_pkg::*;
  `include "source_lexer_tokenizer_core_defines.svh"

  typedef struct packed {
    logic                   vld;
    logic [3:0]             cls;
    logic [5:0]             sub;
    logic [2:0]             err;
    logic [7:0]             cv;
    logic [OFFSET_BITS-1:0] so;
    logic [LINE_BITS-1:0]   sl;
    logic [COL_BITS-1:0]    sc;
    logic [OFFSET_BITS-1:0] eo;
    logic [LINE_BITS-1:0]   el;
    logic [COL_BITS-1:0]    ec;
  } rec_t;

  rec_t [2:0] ent;
  rec_t       sel;
  logic [2:0] rem, pick, done_q, done_d;
  logic       ov_q, ov_d, adv, load;

  assign ent = head_i;
  assign rem = {ent[2].vld, ent[1].vld, ent[0].vld} & ~done_q;

  always_comb begin
    pick = '0;
    sel  = ent[0];
    if (rem[0]) begin
      pick = 3'b001;
      sel  = ent[0];
    end else if (rem[1]) begin
      pick = 3'b010;
      sel  = ent[1];
    end else begin
      pick = 3'b100;
      sel  = ent[2];
    end
  end

  assign adv  = !ov_q || ready_i;
  assign load = adv && !empty_i;

  always_comb begin
    ov_d   = ov_q;
    done_d = done_q;
    pop_o  = 1'b0;
    if (adv) ov_d = load;
    if (load) begin
      if ((rem & ~pick) == '0) begin
        pop_o  = 1'b1;
        done_d = '0;
      end else begin
        done_d = done_q | pick;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q   <= 1'b0;
      done_q <= '0;
    end else begin
      ov_q   <= ov_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      token_class_o  <= sel.cls;
      sub_code_o     <= sel.sub;
      error_code_o   <= sel.err;
      start_offset_o <= sel.so;
      token_length_o <= sel.eo - sel.so;
      line_from_o    <= sel.sl;
      col_from_o     <= sel.sc;
      line_to_o      <= sel.el;
      col_to_o       <= sel.ec;
      char_value_o   <= sel.cv;
      last_o         <= ((rem & ~pick) == '0);
    end
  end

  assign valid_o = ov_q;

  `SLT_IMPLY(a_back_err_class, ov_q && error_code_o != ERR_NONE,
             token_class_o == CLS_ERROR || token_class_o == CLS_DIAG,
             "error code on a non-error token")
  `SLT_IMPLY(a_back_eof_last, ov_q && token_class_o == CLS_EOF, last_o,
             "end of source token not last of its item")
  `SLT_IMPLY(a_back_pick_live, load, (rem & pick) != '0,
             "emitter picked an empty record")
endmodule

/* sim/tb_slt_token_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lexer token checker
// watches the byte and token channels, works out the tokens each accepted
// item should give and compares every accepted token, field by field, with
// the oldest token still owed
// ----------------------------------------------------------------------------
module tb_slt_token_checker (
  input  logic clk_i,
  input  logic rst_ni,
  slt_in_if    in_mon,
  slt_out_if   out_mon,
  output int   fail_count,
  output int   pending
);
  import slt_pkg::*;

  typedef struct packed {
    logic [3:0]  cls;
    logic [5:0]  sub;
    logic [2:0]  err;
    logic [23:0] so;
    logic [23:0] len;
    logic [19:0] sl;
    logic [15:0] sc;
    logic [19:0] el;
    logic [15:0] ec;
    logic [7:0]  cv;
    logic        last;
  } token_t;

  token_t owed_tokens[$];
  token_t step_toks[4];
  int     n_toks;

  mode_e       mode;
  logic [7:0]  word_buf[10];
  int          word_len;
  logic        word_long;
  logic        in_escape;
  logic [7:0]  held;
  logic [23:0] tok_off, cur_off, dot_off;
  logic [19:0] tok_line, cur_line, dot_line;
  logic [15:0] tok_col, cur_col, dot_col;

  task automatic clear_scan();
    mode = ST_IDLE;
    word_len = 0; word_long = 0; in_escape = 0; held = '0;
    tok_off = '0; tok_line = 20'd1; tok_col = 16'd1;
    cur_off = '0; cur_line = 20'd1; cur_col = 16'd1;
    dot_off = '0; dot_line = 20'd1; dot_col = 16'd1;
  endtask

  task automatic add_span(input logic [3:0] cls, input logic [5:0] sub,
                          input logic [2:0] err, input logic [7:0] cv,
                          input logic [23:0] so, input logic [19:0] sl,
                          input logic [15:0] sc, input logic [23:0] eo,
                          input logic [19:0] el, input logic [15:0] ec);
    token_t t;
    if (n_toks < 4) begin
      t.cls = cls; t.sub = sub; t.err = err; t.cv = cv;
      t.so = so; t.len = (eo >= so) ? eo - so : '0;
      t.sl = sl; t.sc = sc; t.el = el; t.ec = ec; t.last = 1'b0;
      step_toks[n_toks] = t;
      n_toks++;
    end
  endtask

  task automatic add_here(input logic [3:0] cls, input logic [5:0] sub,
                          input logic [2:0] err, input logic [7:0] cv);
    add_span(cls, sub, err, cv, tok_off, tok_line, tok_col, cur_off, cur_line, cur_col);
  endtask

  task automatic advance(input logic [7:0] b);
    if (cur_off != '1) cur_off++;
    if (b == CH_LF) begin
      if (cur_line != '1) cur_line++;
      cur_col = 16'd1;
    end else if (cur_col != '1) begin
      cur_col++;
    end
  endtask

  function automatic logic alpha_b(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == CH_USCORE;
  endfunction

  function automatic logic digit_b(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic int one_char_op(input logic [7:0] b);
    case (b)
      CH_LPAREN: return OP_LPAREN;  CH_RPAREN: return OP_RPAREN;
      CH_LBRACE: return OP_LBRACE;  CH_RBRACE: return OP_RBRACE;
      CH_LBRACK: return OP_LBRACK;  CH_RBRACK: return OP_RBRACK;
      CH_SEMI:   return OP_SEMI;    CH_COMMA:  return OP_COMMA;
      CH_COLON:  return OP_COLON;   CH_DOT:    return OP_DOT;
      CH_QUEST:  return OP_QUEST;   CH_PLUS:   return OP_ADD;
      CH_MINUS:  return OP_SUB;     CH_STAR:   return OP_MUL;
      CH_SLASH:  return OP_DIV;     CH_PCT:    return OP_MOD;
      CH_EQ:     return OP_ASSIGN;  CH_BANG:   return OP_NOT;
      CH_LT:     return OP_LT;      CH_GT:     return OP_GT;
      default:   return -1;
    endcase
  endfunction

  function automatic int two_char_op(input logic [7:0] a, input logic [7:0] b);
    if (a == CH_PLUS && b == CH_PLUS) return OP_INC;
    if (a == CH_PLUS && b == CH_EQ) return OP_ADDEQ;
    if (a == CH_MINUS && b == CH_MINUS) return OP_DEC;
    if (a == CH_MINUS && b == CH_EQ) return OP_SUBEQ;
    if (a == CH_MINUS && b == CH_GT) return OP_ARROW;
    if (a == CH_STAR && b == CH_EQ) return OP_MULEQ;
    if (a == CH_SLASH && b == CH_EQ) return OP_DIVEQ;
    if (a == CH_EQ && b == CH_EQ) return OP_EQ;
    if (a == CH_BANG && b == CH_EQ) return OP_NE;
    if (a == CH_LT && b == CH_EQ) return OP_LE;
    if (a == CH_GT && b == CH_EQ) return OP_GE;
    if (a == CH_AMP && b == CH_AMP) return OP_LAND;
    if (a == CH_PIPE && b == CH_PIPE) return OP_LOR;
    return -1;
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] b);
    case (b)
      CH_N:    return CH_LF;
      CH_T:    return CH_TAB;
      CH_R:    return CH_CR;
      default: return b;
    endcase
  endfunction

  task automatic emit_word();
    logic [79:0] w;
    w = '0;
    if (!word_long) begin
      for (int i = 0; i < word_len; i++) w = {w[71:0], word_buf[i]};
      for (int i = 0; i < KW_COUNT; i++) begin
        if (KW_TEXT[i] == w) begin
          add_here(CLS_KEYWORD, KW_CODE[i], ERR_NONE, 8'd0);
          return;
        end
      end
    end
    add_here(CLS_IDENT, 6'd0, ERR_NONE, 8'd0);
  endtask

  // emits the token left open in the current mode
  task automatic close_token();
    int c;
    case (mode)
      ST_IDENT: emit_word();
      ST_NUM:   add_here(CLS_INT, 6'd0, ERR_NONE, 8'd0);
      ST_NUMDOT: begin
        add_span(CLS_INT, 6'd0, ERR_NONE, 8'd0, tok_off, tok_line, tok_col,
                 dot_off, dot_line, dot_col);
        add_span(CLS_OP, OP_DOT, ERR_NONE, 8'd0, dot_off, dot_line, dot_col,
                 cur_off, cur_line, cur_col);
      end
      ST_FRAC:  add_here(CLS_FLOAT, 6'd0, ERR_NONE, 8'd0);
      ST_STR:   add_here(CLS_ERROR, 6'd0, ERR_OPEN_STRING, 8'd0);
      ST_COPEN, ST_CESC: add_here(CLS_ERROR, 6'd0, ERR_BAD_CHAR, 8'd0);
      ST_CGOT:  add_here(CLS_ERROR, 6'd0, ERR_BAD_CHAR, held);
      ST_OP: begin
        c = one_char_op(held);
        if (c >= 0) add_here(CLS_OP, 6'(c), ERR_NONE, 8'd0);
        else add_here(CLS_ERROR, 6'd0, ERR_UNEXPECTED, held);
      end
      ST_BLOCK, ST_BSTAR: add_here(CLS_DIAG, 6'd0, ERR_OPEN_COMMENT, 8'd0);
      default: ;
    endcase
    mode = ST_IDLE;
  endtask

  task automatic start_token(input logic [7:0] b);
    int c;
    if (b == CH_SPACE || b == CH_CR || b == CH_TAB || b == CH_LF) begin
      advance(b);
      return;
    end
    tok_off = cur_off; tok_line = cur_line; tok_col = cur_col;
    advance(b);
    if (alpha_b(b)) begin
      word_buf[0] = b; word_len = 1; word_long = 0; mode = ST_IDENT;
    end else if (digit_b(b)) begin
      mode = ST_NUM;
    end else if (b == CH_DQUOTE) begin
      in_escape = 0; mode = ST_STR;
    end else if (b == CH_SQUOTE) begin
      held = '0; mode = ST_COPEN;
    end else if (b == CH_PLUS || b == CH_MINUS || b == CH_STAR || b == CH_SLASH ||
                 b == CH_EQ || b == CH_BANG || b == CH_LT || b == CH_GT ||
                 b == CH_AMP || b == CH_PIPE) begin
      held = b; mode = ST_OP;
    end else begin
      c = one_char_op(b);
      if (c >= 0) add_here(CLS_OP, 6'(c), ERR_NONE, 8'd0);
      else add_here(CLS_ERROR, 6'd0, ERR_UNEXPECTED, b);
    end
  endtask

  task automatic scan_byte(input logic [7:0] b);
    int  c;
    bit  done;
    done = 0;
    while (!done) begin
      done = 1;
      case (mode)
        ST_IDLE: start_token(b);
        ST_LINE: begin
          if (b == CH_LF) mode = ST_IDLE;
          advance(b);
        end
        ST_BLOCK: begin
          if (b == CH_STAR) mode = ST_BSTAR;
          advance(b);
        end
        ST_BSTAR: begin
          if (b == CH_SLASH) mode = ST_IDLE;
          else if (b != CH_STAR) mode = ST_BLOCK;
          advance(b);
        end
        ST_IDENT: begin
          if (alpha_b(b) || digit_b(b)) begin
            if (word_len < 10) begin
              word_buf[word_len] = b;
              word_len++;
            end else begin
              word_long = 1;
            end
            advance(b);
          end else done = 0;
        end
        ST_NUM: begin
          if (digit_b(b)) advance(b);
          else if (b == CH_DOT) begin
            dot_off = cur_off; dot_line = cur_line; dot_col = cur_col;
            advance(b);
            mode = ST_NUMDOT;
          end else done = 0;
        end
        ST_NUMDOT: begin
          if (digit_b(b)) begin
            advance(b);
            mode = ST_FRAC;
          end else done = 0;
        end
        ST_FRAC: begin
          if (digit_b(b)) advance(b);
          else done = 0;
        end
        ST_STR: begin
          if (in_escape) in_escape = 0;
          else if (b == CH_BSLASH) in_escape = 1;
          else if (b == CH_DQUOTE) begin
            advance(b);
            add_here(CLS_STRING, 6'd0, ERR_NONE, 8'd0);
            mode = ST_IDLE;
          end
          if (mode == ST_STR) advance(b);
        end
        ST_COPEN: begin
          if (b == CH_SQUOTE) begin
            add_here(CLS_ERROR, 6'd0, ERR_EMPTY_CHAR, 8'd0);
            mode = ST_IDLE;
          end else if (b == CH_BSLASH) begin
            mode = ST_CESC;
          end else begin
            held = b;
            mode = ST_CGOT;
          end
          advance(b);
        end
        ST_CESC: begin
          held = unescape(b);
          mode = ST_CGOT;
          advance(b);
        end
        ST_CGOT: begin
          if (b == CH_SQUOTE) begin
            advance(b);
            add_here(CLS_CHAR, 6'd0, ERR_NONE, held);
            mode = ST_IDLE;
          end else done = 0;
        end
        ST_OP: begin
          c = two_char_op(held, b);
          if (c >= 0) begin
            advance(b);
            add_here(CLS_OP, 6'(c), ERR_NONE, 8'd0);
            mode = ST_IDLE;
          end else if (held == CH_SLASH && b == CH_SLASH) begin
            mode = ST_LINE;
            advance(b);
          end else if (held == CH_SLASH && b == CH_STAR) begin
            mode = ST_BLOCK;
            advance(b);
          end else done = 0;
        end
        default: begin
          mode = ST_IDLE;
          done = 0;
        end
      endcase
      if (!done && mode != ST_IDLE) close_token();
    end
  endtask

  task automatic check_field(input string name, input logic [23:0] exp_v,
                             input logic [23:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    clear_scan();
  end

  always @(posedge clk_i or negedge rst_ni) begin
    token_t got, want;
    if (!rst_ni) begin
      clear_scan();
      owed_tokens.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        n_toks = 0;
        if (in_mon.kind) begin
          close_token();
          add_span(CLS_EOF, 6'd0, ERR_NONE, 8'd0, cur_off, cur_line, cur_col,
                   cur_off, cur_line, cur_col);
          clear_scan();
        end else begin
          scan_byte(in_mon.byte_in);
        end
        if (n_toks > 0) step_toks[n_toks-1].last = 1'b1;
        for (int i = 0; i < n_toks; i++) owed_tokens.insert(owed_tokens.size(), step_toks[i]);
      end
      if (out_mon.valid && out_mon.ready) begin
        got.cls = out_mon.token_class;  got.sub = out_mon.sub_code;
        got.err = out_mon.error_code;   got.so = out_mon.start_offset;
        got.len = out_mon.token_length; got.sl = out_mon.line_from;
        got.sc = out_mon.col_from;      got.el = out_mon.line_to;
        got.ec = out_mon.col_to;        got.cv = out_mon.char_value;
        got.last = out_mon.last;
        if (owed_tokens.size() == 0) begin
          $display("%0t ns: token with none expected, expected nothing, got class %0d",
                   $time, got.cls);
          fail_count++;
        end else begin
          want = owed_tokens.pop_front();
          check_field("token_class", want.cls, got.cls);
          check_field("sub_code", want.sub, got.sub);
          check_field("error_code", want.err, got.err);
          check_field("start_offset", want.so, got.so);
          check_field("token_length", want.len, got.len);
          check_field("line_from", want.sl, got.sl);
          check_field("col_from", want.sc, got.sc);
          check_field("line_to", want.el, got.el);
          check_field("col_to", want.ec, got.ec);
          check_field("char_value", want.cv, got.cv);
          check_field("last", want.last, got.last);
        end
      end
    end
    pending = owed_tokens.size();
  end

endmodule

/* sim/tb_source_lexer_tokenizer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lexer tokenizer testbench
// feeds directed and random source text with end-of-source items through the
// byte channel under bursty traffic and a stalling token sink; the checker
// beside the core predicts and compares every token
// ----------------------------------------------------------------------------
module tb_source_lexer_tokenizer_core;
  import slt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEM_GOAL   = 360;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   cycles;
  int   burst_left;
  int   items_sent;
  bit   drained;
  logic [7:0] src_bytes[$];

  slt_in_if  byte_ch ();
  slt_out_if tok_ch ();

  source_lexer_tokenizer_core uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (byte_ch.sink),
    .out_o (tok_ch.source)
  );

  tb_slt_token_checker checker_i (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (byte_ch),
    .out_mon   (tok_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // sink stall pattern is chosen by cycle counter bits 9:8
  always @(negedge clk_i) begin
    case (cycles[9:8])
      2'd0: tok_ch.ready <= 1'b1;
      2'd1: tok_ch.ready <= ($urandom_range(0, 1) == 0);
      2'd2: tok_ch.ready <= (cycles[2:0] > 3'd2);
      default: tok_ch.ready <= ($urandom_range(0, 9) < 8);
    endcase
  end

  task automatic send_item(input logic k, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        byte_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 8);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.kind    <= k;
    byte_ch.byte_in <= b;
    do @(posedge clk_i); while (!byte_ch.ready);
    @(negedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_source();
    while (src_bytes.size() > 0) send_item(1'b0, src_bytes.pop_front());
    send_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic put_byte(input logic [7:0] b);
    src_bytes.insert(src_bytes.size(), b);
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  function automatic logic [7:0] word_char(input bit lead);
    int r;
    r = $urandom_range(0, lead ? 52 : 62);
    if (r < 26) return 8'("a") + 8'(r);
    if (r < 52) return 8'("A") + 8'(r - 26);
    if (r == 52) return CH_USCORE;
    return 8'("0") + 8'(r - 53);
  endfunction

  task automatic put_piece();
    logic [7:0] ops[$];
    int n, k;
    ops = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_EQ, CH_BANG, CH_LT, CH_GT,
            CH_AMP, CH_PIPE, CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE,
            CH_LBRACK, CH_RBRACK, CH_SEMI, CH_COMMA, CH_COLON, CH_DOT,
            CH_QUEST, CH_PCT};
    case ($urandom_range(0, 13))
      0, 1: begin
        k = $urandom_range(0, KW_COUNT - 1);
        for (int c = 9; c >= 0; c--)
          if (KW_TEXT[k][c*8 +: 8] != 8'd0) put_byte(KW_TEXT[k][c*8 +: 8]);
      end
      2: begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 6);
        put_byte(word_char(1));
        repeat (n - 1) put_byte(word_char(0));
      end
      3: repeat ($urandom_range(1, 4)) put_byte(8'("0") + 8'($urandom_range(0, 9)));
      4: begin
        put_byte(8'("0") + 8'($urandom_range(0, 9)));
        put_byte(CH_DOT);
        if ($urandom_range(0, 1)) put_byte(8'("0") + 8'($urandom_range(0, 9)));
      end
      5: begin
        put_byte(CH_DQUOTE);
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(0, 3) == 0) put_byte(CH_BSLASH);
          put_byte(8'($urandom_range(32, 126)));
        end
        put_byte(CH_DQUOTE);
      end
      6: begin
        put_byte(CH_SQUOTE);
        case ($urandom_range(0, 4))
          0: put_byte(CH_SQUOTE);
          1: begin
            put_byte(CH_BSLASH);
            put_byte(($urandom_range(0, 1)) ? CH_N : 8'($urandom_range(32, 126)));
            put_byte(CH_SQUOTE);
          end
          2: put_byte(8'($urandom_range(32, 126)));
          default: begin
            put_byte(8'($urandom_range(32, 126)));
            put_byte(CH_SQUOTE);
          end
        endcase
      end
      7, 8: begin
        put_byte(ops[$urandom_range(0, ops.size() - 1)]);
        if ($urandom_range(0, 1)) put_byte(ops[$urandom_range(0, 9)]);
      end
      9: begin
        put_str("//");
        repeat ($urandom_range(0, 4)) put_byte(8'($urandom_range(32, 126)));
        put_byte(CH_LF);
      end
      10: begin
        put_str("/*");
        repeat ($urandom_range(0, 4))
          put_byte(($urandom_range(0, 2) == 0) ? CH_STAR : 8'($urandom_range(0, 255)));
        put_str("*/");
      end
      11: put_byte(8'($urandom_range(0, 255)));
      default: begin
        case ($urandom_range(0, 3))
          0: put_byte(CH_SPACE);
          1: put_byte(CH_TAB);
          2: put_byte(CH_CR);
          default: put_byte(CH_LF);
        endcase
      end
    endcase
    if ($urandom_range(0, 2) != 0) put_byte(CH_SPACE);
  endtask

  initial begin
    cycles          = 0;
    burst_left      = 0;
    items_sent      = 0;
    drained         = 1'b0;
    rst_ni          = 1'b0;
    byte_ch.valid   = 1'b0;
    byte_ch.kind    = 1'b0;
    byte_ch.byte_in = 8'd0;
    tok_ch.ready    = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty char, int then dot, long word, lone amp, high byte, bad char
    put_str("''1.x abcdefghijk&");
    put_byte(8'hFF);
    put_str("'ab");
    put_byte(8'h01);
    send_source();
    put_str("\"a\\");
    send_source();
    put_str("/*");
    send_source();

    while (items_sent < ITEM_GOAL) begin
      repeat ($urandom_range(3, 12)) put_piece();
      case ($urandom_range(0, 5))
        0: put_str("\"x");
        1: put_str("/* q");
        default: ;
      endcase
      send_source();
      if (!drained && items_sent > ITEM_GOAL / 2) begin
        drained = 1'b1;
        byte_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk_i);
      end
    end

    byte_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* source_lexer_tokenizer_core.f */
+incdir+hw/rtl
hw/rtl/slt_pkg.sv
hw/rtl/slt_ifs.sv
hw/rtl/slt_fifo.sv
hw/rtl/slt_front.sv
hw/rtl/slt_back.sv
hw/rtl/source_lexer_tokenizer_core.sv
sim/tb_slt_token_checker.sv
sim/tb_source_lexer_tokenizer_core.sv
